>>> rtl/psr_pkg.sv
package psr_pkg;

  // field widths
  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned COLOUR_W    = 16;
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned SCALE_W     = 4;
  localparam int unsigned STRIDE_W    = 13;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_INDEX_W = 3;

  // source image and magnification limits
  localparam int unsigned SRC_WIDTH  = 256;
  localparam int unsigned SRC_HEIGHT = 144;
  localparam int unsigned MAX_SCALE  = 8;
  localparam int unsigned CNT_W      = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  // default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TRANSPOSE = 3'd0,
    REG_FLIP_ROWS = 3'd1,
    REG_FLIP_COLS = 3'd2,
    REG_SWAP      = 3'd3,
    REG_SCALE     = 3'd4,
    REG_STRIDE    = 3'd5,
    REG_BASE      = 3'd6
  } reg_index_t;

  // configuration register file
  typedef struct packed {
    logic                transpose_axes;
    logic                flip_rows;
    logic                flip_columns;
    logic                swap_colour_bytes;
    logic [SCALE_W-1:0]  scale_factor;
    logic [STRIDE_W-1:0] row_stride;
    logic [ADDR_W-1:0]   base_address;
  } cfg_t;

  // one prepared pixel, ready to be expanded into writes
  typedef struct packed {
    logic [ADDR_W-1:0]   row_base;
    logic [ADDR_W-1:0]   col_base;
    logic [COLOUR_W-1:0] colour;
    logic [CNT_W-1:0]    scale_m1;
  } job_t;

endpackage

>>> rtl/psr_front.sv
module psr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  psr_pkg::cfg_t                 cfg,
  input  logic                          push,
  output logic                          full,
  input  logic [psr_pkg::PIXEL_W-1:0]   source_pixel,
  input  logic [psr_pkg::POS_W-1:0]     source_column,
  input  logic [psr_pkg::POS_W-1:0]     source_row,
  output logic                          job_valid,
  input  logic                          job_ready,
  output psr_pkg::job_t                 job
);
  import psr_pkg::*;

  // stage 1: colour and mapped position
  logic                v1;
  logic [COLOUR_W-1:0] s1_colour;
  logic [ADDR_W-1:0]   s1_outer;
  logic [ADDR_W-1:0]   s1_inner;
  logic [SCALE_W-1:0]  s1_scale;

  // stage 2: positions times scale
  logic                v2;
  logic [COLOUR_W-1:0] s2_colour;
  logic [ADDR_W-1:0]   s2_outer;
  logic [ADDR_W-1:0]   s2_inner;
  logic [SCALE_W-1:0]  s2_scale;

  // stage 3: row base address
  logic                v3;
  job_t                s3_job;

  logic rdy1, rdy2, rdy3;
  logic accept;

  logic [COLOUR_W-1:0] colour565;
  logic [COLOUR_W-1:0] colour_sel;
  logic [ADDR_W-1:0]   col_ext, row_ext;
  logic [ADDR_W-1:0]   outer_raw, inner_raw;
  logic [ADDR_W-1:0]   outer_cnt_m1, inner_cnt_m1;
  logic [ADDR_W-1:0]   outer_map, inner_map;
  logic [SCALE_W-1:0]  scale_clamped;

  // stall chain
  assign rdy3   = !v3 || job_ready;
  assign rdy2   = !v2 || rdy3;
  assign rdy1   = !v1 || rdy2;
  assign full   = !rdy1;
  assign accept = push && rdy1;

  assign job_valid = v3;
  assign job       = s3_job;

  // colour conversion and optional byte swap
  assign colour565  = {source_pixel[23:19], source_pixel[15:10], source_pixel[7:3]};
  assign colour_sel = cfg.swap_colour_bytes ? {colour565[7:0], colour565[15:8]} : colour565;

  // axis selection and mirroring, wrapping modulo the address width
  assign col_ext = ADDR_W'(source_column);
  assign row_ext = ADDR_W'(source_row);

  always_comb begin
    if (cfg.transpose_axes) begin
      outer_raw    = col_ext;
      inner_raw    = row_ext;
      outer_cnt_m1 = ADDR_W'(SRC_WIDTH - 1);
      inner_cnt_m1 = ADDR_W'(SRC_HEIGHT - 1);
    end else begin
      outer_raw    = row_ext;
      inner_raw    = col_ext;
      outer_cnt_m1 = ADDR_W'(SRC_HEIGHT - 1);
      inner_cnt_m1 = ADDR_W'(SRC_WIDTH - 1);
    end
  end

  assign outer_map = cfg.flip_rows    ? (outer_cnt_m1 - outer_raw) : outer_raw;
  assign inner_map = cfg.flip_columns ? (inner_cnt_m1 - inner_raw) : inner_raw;

  // zero acts as one, anything above the limit acts as the limit
  always_comb begin
    priority if (cfg.scale_factor == '0) begin
      scale_clamped = SCALE_W'(1);
    end else if (cfg.scale_factor > SCALE_W'(MAX_SCALE)) begin
      scale_clamped = SCALE_W'(MAX_SCALE);
    end else begin
      scale_clamped = cfg.scale_factor;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= push;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_colour <= colour_sel;
      s1_outer  <= outer_map;
      s1_inner  <= inner_map;
      s1_scale  <= scale_clamped;
    end
    if (rdy2 && v1) begin
      s2_colour <= s1_colour;
      s2_outer  <= s1_outer * ADDR_W'(s1_scale);
      s2_inner  <= s1_inner * ADDR_W'(s1_scale);
      s2_scale  <= s1_scale;
    end
    if (rdy3 && v2) begin
      s3_job.row_base <= cfg.base_address + s2_outer * ADDR_W'(cfg.row_stride);
      s3_job.col_base <= s2_inner;
      s3_job.colour   <= s2_colour;
      s3_job.scale_m1 <= CNT_W'(s2_scale - SCALE_W'(1));
    end
  end

endmodule

>>> rtl/psr_queue.sv
module psr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign in_ready  = count != CNT_W'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = slots[head];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      if (do_pop)  head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots[tail] <= in_data;
  end

endmodule

>>> rtl/psr_back.sv
module psr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [psr_pkg::STRIDE_W-1:0]  row_stride,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  psr_pkg::job_t                 job,
  output logic                          empty,
  input  logic                          pop,
  output logic [psr_pkg::ADDR_W-1:0]    write_address,
  output logic [psr_pkg::COLOUR_W-1:0]  write_colour,
  output logic                          last_write
);
  import psr_pkg::*;

  // current pixel being expanded
  logic                busy;
  logic [ADDR_W-1:0]   row_base;
  logic [ADDR_W-1:0]   col_base;
  logic [ADDR_W-1:0]   col_cur;
  logic [COLOUR_W-1:0] colour;
  logic [CNT_W-1:0]    scale_m1;
  logic [CNT_W-1:0]    dx, dy;

  // output word register
  logic                out_valid;

  logic out_load, step, at_last, at_row_end, done, take;

  assign out_load   = !out_valid || pop;
  assign step       = busy && out_load;
  assign at_row_end = dx == scale_m1;
  assign at_last    = at_row_end && (dy == scale_m1);
  assign done       = step && at_last;
  assign take       = job_valid && (!busy || done);
  assign job_ready  = !busy || done;
  assign empty      = !out_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (step) begin
      write_address <= row_base + col_cur;
      write_colour  <= colour;
      last_write    <= at_last;
    end
  end

  // dx inner, dy outer; addresses advance by one pixel or by one stride
  always_ff @(posedge clk) begin
    if (take) begin
      row_base <= job.row_base;
      col_base <= job.col_base;
      col_cur  <= job.col_base;
      colour   <= job.colour;
      scale_m1 <= job.scale_m1;
      dx       <= '0;
      dy       <= '0;
    end else if (step && !at_last) begin
      if (at_row_end) begin
        dx       <= '0;
        dy       <= dy + CNT_W'(1);
        col_cur  <= col_base;
        row_base <= row_base + ADDR_W'(row_stride);
      end else begin
        dx      <= dx + CNT_W'(1);
        col_cur <= col_cur + ADDR_W'(1);
      end
    end
  end

endmodule

>>> rtl/pixel_scale_rotate_rgb565_writer.sv
// Nearest-neighbor scale and rotate writer for RGB565 framebuffers.
// Input side is a queue: drive source_pixel, source_column and source_row with
// push; the word is taken at a clock edge where push is high and full is low.
// Output side is a queue too: while empty is low the oldest framebuffer write
// sits on write_address, write_colour and last_write; pop takes it.
// Each pixel gives scale*scale writes, inner axis fastest, last_write set on
// the final one. The back end issues one write per cycle while pop keeps the
// output register free, and pixels follow each other with no gap while the
// job queue holds the next one; the expander's dx/dy counter walks the writes.
// An accepted pixel passes through three front stages (map, scale multiply,
// stride multiply), the job queue, the expander's pixel registers and the
// output register before its first write reaches the ports.
// When pop is held low the output register holds its word, the expander waits,
// the job queue fills and finally full rises; nothing is dropped.
// Configuration goes through cfg_we/cfg_index/cfg_data and must only change
// while no pixel is in flight. Reset (rst, synchronous) empties the pipeline
// and queue and returns the registers to scale 1, stride 1, everything else 0.
module pixel_scale_rotate_rgb565_writer #(
  parameter int unsigned QUEUE_DEPTH = psr_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [psr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [psr_pkg::PIXEL_W-1:0]     source_pixel,
  input  logic [psr_pkg::POS_W-1:0]       source_column,
  input  logic [psr_pkg::POS_W-1:0]       source_row,
  output logic                            empty,
  input  logic                            pop,
  output logic [psr_pkg::ADDR_W-1:0]      write_address,
  output logic [psr_pkg::COLOUR_W-1:0]    write_colour,
  output logic                            last_write
);
  import psr_pkg::*;

  cfg_t cfg;

  logic front_valid, front_ready;
  job_t front_job;
  logic back_valid, back_ready;
  job_t back_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transpose_axes    <= 1'b0;
      cfg.flip_rows         <= 1'b0;
      cfg.flip_columns      <= 1'b0;
      cfg.swap_colour_bytes <= 1'b0;
      cfg.scale_factor      <= SCALE_W'(1);
      cfg.row_stride        <= STRIDE_W'(1);
      cfg.base_address      <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_TRANSPOSE: cfg.transpose_axes    <= cfg_data[0];
        REG_FLIP_ROWS: cfg.flip_rows         <= cfg_data[0];
        REG_FLIP_COLS: cfg.flip_columns      <= cfg_data[0];
        REG_SWAP:      cfg.swap_colour_bytes <= cfg_data[0];
        REG_SCALE:     cfg.scale_factor      <= cfg_data[SCALE_W-1:0];
        REG_STRIDE:    cfg.row_stride        <= cfg_data[STRIDE_W-1:0];
        REG_BASE:      cfg.base_address      <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // front: colour conversion, axis mapping, base addresses
  psr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .push          (push),
    .full          (full),
    .source_pixel  (source_pixel),
    .source_column (source_column),
    .source_row    (source_row),
    .job_valid     (front_valid),
    .job_ready     (front_ready),
    .job           (front_job)
  );

  // job queue between front and back
  psr_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_job),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_data  (back_job)
  );

  // back: expands each pixel into scale*scale writes
  psr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .row_stride    (cfg.row_stride),
    .job_valid     (back_valid),
    .job_ready     (back_ready),
    .job           (back_job),
    .empty         (empty),
    .pop           (pop),
    .write_address (write_address),
    .write_colour  (write_colour),
    .last_write    (last_write)
  );

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import psr_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PERCENT = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  // one framebuffer write as the block should issue it
  typedef struct {
    logic [ADDR_W-1:0]   addr;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } fb_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [PIXEL_W-1:0] source_pixel = '0;
  logic [POS_W-1:0] source_column = '0;
  logic [POS_W-1:0] source_row = '0;
  logic empty;
  logic pop = 1'b0;
  logic [ADDR_W-1:0] write_address;
  logic [COLOUR_W-1:0] write_colour;
  logic last_write;

  cfg_t regs_shadow;
  fb_write_t pending_writes[$];
  int errors = 0;
  int stall_cycles = 0;
  bit steady = 1'b0;

  pixel_scale_rotate_rgb565_writer DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .source_pixel(source_pixel),
    .source_column(source_column),
    .source_row(source_row),
    .empty(empty),
    .pop(pop),
    .write_address(write_address),
    .write_colour(write_colour),
    .last_write(last_write)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  // expand one pixel into its scale*scale framebuffer writes
  function automatic void predict_pixel_writes(logic [PIXEL_W-1:0] px,
                                               logic [POS_W-1:0] col,
                                               logic [POS_W-1:0] row);
    logic [COLOUR_W-1:0] colour;
    logic [ADDR_W-1:0] outer, inner, outer_len, inner_len;
    logic [ADDR_W-1:0] prow, row_base, pcol;
    logic [SCALE_W-1:0] scale;
    fb_write_t w;
    colour = {px[23:19], px[15:10], px[7:3]};
    if (regs_shadow.swap_colour_bytes) colour = {colour[7:0], colour[15:8]};
    scale = regs_shadow.scale_factor;
    if (scale == 0) scale = SCALE_W'(1);
    if (scale > MAX_SCALE) scale = SCALE_W'(MAX_SCALE);
    if (regs_shadow.transpose_axes) begin
      outer = ADDR_W'(col);
      inner = ADDR_W'(row);
      outer_len = ADDR_W'(SRC_WIDTH);
      inner_len = ADDR_W'(SRC_HEIGHT);
    end else begin
      outer = ADDR_W'(row);
      inner = ADDR_W'(col);
      outer_len = ADDR_W'(SRC_HEIGHT);
      inner_len = ADDR_W'(SRC_WIDTH);
    end
    // mirrored index may go below zero and wrap
    if (regs_shadow.flip_rows) outer = ADDR_W'(outer_len - 1 - outer);
    if (regs_shadow.flip_columns) inner = ADDR_W'(inner_len - 1 - inner);
    for (int dy = 0; dy < scale; dy++) begin
      prow = ADDR_W'(outer * scale + dy);
      row_base = regs_shadow.base_address + prow * regs_shadow.row_stride;
      for (int dx = 0; dx < scale; dx++) begin
        pcol = ADDR_W'(inner * scale + dx);
        w.addr = row_base + pcol;
        w.colour = colour;
        w.last = (dy == scale - 1) && (dx == scale - 1);
        pending_writes.push_back(w);
      end
    end
  endfunction

  // result side: random pop stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= !take_break();
    end
  end

  // accepted pixels feed the predictor, accepted writes are checked in order
  always @(posedge clk) begin
    fb_write_t want;
    if (!rst) begin
      if (push && !full) predict_pixel_writes(source_pixel, source_column, source_row);
      if (pop && !empty) begin
        if (pending_writes.size() == 0) begin
          $error("unexpected write: address %h colour %h last %b",
                 write_address, write_colour, last_write);
          errors++;
        end else begin
          want = pending_writes.pop_front();
          if (write_address !== want.addr) begin
            $error("write_address: expected %h, got %h", want.addr, write_address);
            errors++;
          end
          if (write_colour !== want.colour) begin
            $error("write_colour: expected %h, got %h", want.colour, write_colour);
            errors++;
          end
          if (last_write !== want.last) begin
            $error("last_write: expected %b, got %b", want.last, last_write);
            errors++;
          end
        end
      end
      // watchdog on cycles with no progress
      if ((push && !full) || (pop && !empty) || cfg_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // hand one pixel to the block, waiting out full
  task automatic send_pixel(logic [PIXEL_W-1:0] px, logic [POS_W-1:0] col,
                            logic [POS_W-1:0] row);
    while (take_break()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    source_pixel <= px;
    source_column <= col;
    source_row <= row;
    do @(posedge clk); while (full);
  endtask

  // stop pushing and let every outstanding write come out
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_TRANSPOSE: regs_shadow.transpose_axes = data[0];
      REG_FLIP_ROWS: regs_shadow.flip_rows = data[0];
      REG_FLIP_COLS: regs_shadow.flip_columns = data[0];
      REG_SWAP:      regs_shadow.swap_colour_bytes = data[0];
      REG_SCALE:     regs_shadow.scale_factor = data[SCALE_W-1:0];
      REG_STRIDE:    regs_shadow.row_stride = data[STRIDE_W-1:0];
      REG_BASE:      regs_shadow.base_address = data[ADDR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // reprogram every register once the block is idle; junk in unused upper bits
  task automatic set_config(bit tr, bit fr, bit fc, bit sw, logic [SCALE_W-1:0] sc,
                            logic [STRIDE_W-1:0] st, logic [ADDR_W-1:0] base);
    drain();
    write_reg(REG_TRANSPOSE, {23'($urandom), tr});
    write_reg(REG_FLIP_ROWS, {23'($urandom), fr});
    write_reg(REG_FLIP_COLS, {23'($urandom), fc});
    write_reg(REG_SWAP, {23'($urandom), sw});
    write_reg(REG_SCALE, {20'($urandom), sc});
    write_reg(REG_STRIDE, {11'($urandom), st});
    write_reg(REG_BASE, base);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // reset values: scale 1, stride 1, no mapping, no swap
  task automatic test_reset_defaults();
    send_pixel(32'h0000_0000, 8'd0, 8'd0);
    send_pixel(32'hFFFF_FFFF, 8'd255, 8'd143);
    send_pixel(32'h8012_3456, 8'd17, 8'd255);
  endtask

  // byte swap of the packed color
  task automatic test_colour_swap();
    set_config(1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 13'd320, 24'h001000);
    send_pixel(32'h00F8_0000, 8'd1, 8'd2);
    send_pixel(32'h0000_FC00, 8'd3, 8'd4);
    send_pixel(32'hFF00_00F8, 8'd5, 8'd6);
  endtask

  // every transpose/mirror combination, including wrap of mirrored rows
  task automatic test_mirror_and_transpose();
    for (int m = 0; m < 8; m++) begin
      set_config(m[2], m[1], m[0], m[0], 4'd2, 13'd640, 24'h000100);
      send_pixel($urandom, (m < 4) ? 8'd0 : 8'd255, (m[0]) ? 8'd255 : 8'd143);
    end
  endtask

  // scale zero and above the limit, stride and base at their extremes
  task automatic test_scale_extremes();
    set_config(1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 13'd0, 24'hFFFFFF);
    send_pixel(32'h1234_5678, 8'd255, 8'd143);
    set_config(1'b1, 1'b1, 1'b1, 1'b0, 4'd8, 13'd8191, 24'hFFFFF0);
    send_pixel(32'hFEDC_BA98, 8'd200, 8'd100);
    set_config(1'b0, 1'b1, 1'b0, 1'b1, 4'd15, 13'd4096, 24'h000000);
    send_pixel(32'h0F0F_0F0F, 8'd255, 8'd255);
  endtask

  // a write to an unused index changes nothing
  task automatic test_unknown_index();
    set_config(1'b0, 1'b0, 1'b1, 1'b0, 4'd3, 13'd100, 24'h123456);
    write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_pixel(32'hA5A5_5A5A, 8'd9, 8'd7);
    send_pixel(32'h5A5A_A5A5, 8'd255, 8'd0);
  endtask

  // random settings per phase, random pixels, mostly in-range positions
  task automatic test_random_pixels();
    int roll;
    logic [SCALE_W-1:0] sc;
    logic [STRIDE_W-1:0] st;
    logic [ADDR_W-1:0] base;
    for (int phase = 0; phase < 7; phase++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) sc = 4'd8;
      else if (roll < 18) sc = (roll < 13) ? 4'd0 : 4'($urandom_range(9, 15));
      else sc = 4'($urandom_range(1, 4));
      roll = $urandom_range(0, 99);
      if (roll < 10) st = 13'd0;
      else if (roll < 20) st = 13'd8191;
      else if (roll < 30) st = 13'd4096;
      else st = 13'($urandom_range(1, 8191));
      roll = $urandom_range(0, 99);
      if (roll < 15) base = 24'hFFFFFF - 24'($urandom_range(0, 255));
      else if (roll < 25) base = 24'h0;
      else base = 24'($urandom);
      set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sc, st, base);
      // one phase runs with no idling on either side
      steady = (phase == 3);
      for (int k = 0; k < 27; k++) begin
        send_pixel($urandom, 8'($urandom),
                   ($urandom_range(0, 99) < 20) ? 8'($urandom) : 8'($urandom_range(0, 143)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    regs_shadow = '0;
    regs_shadow.scale_factor = SCALE_W'(1);
    regs_shadow.row_stride = STRIDE_W'(1);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_colour_swap();
    test_mirror_and_transpose();
    test_scale_extremes();
    test_unknown_index();
    test_random_pixels();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_writes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
